/* hdl/mwg_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mwg_pkg
// Shared widths, register indexes and the step helper of the window generator.
// ----------------------------------------------------------------------------
package mwg_pkg;

  localparam int CoordBits  = 12;
  localparam int CountBits  = 4;
  localparam int FactorBits = 16;
  localparam int ShiftBits  = 8;
  localparam int TableBits  = 32;
  localparam int IndexBits  = 5;
  localparam int CfgIdxBits = 3;
  localparam int CfgDatBits = 16;
  localparam int FactorFrac = 12;

  typedef logic [CoordBits-1:0] coord_t;

  typedef enum logic [CfgIdxBits-1:0] {
    REG_BASE_W   = 3'd0,
    REG_BASE_H   = 3'd1,
    REG_IMAGE_W  = 3'd2,
    REG_IMAGE_H  = 3'd3,
    REG_SCALES   = 3'd4,
    REG_FACTOR   = 3'd5,
    REG_MIN_SIDE = 3'd6,
    REG_SHIFT    = 3'd7
  } cfg_reg_t;

  // step = round(shift * size / 256), at least one
  function automatic coord_t step_for(input logic [ShiftBits-1:0] shift, input coord_t size);
    logic [CoordBits+ShiftBits:0] p;
    coord_t s;
    p = {1'b0, 12'(0) + 20'(shift) * 20'(size)} + 21'd128;
    s = p[CoordBits+ShiftBits-1:ShiftBits];
    step_for = (s == '0) ? coord_t'(1) : s;
  endfunction

endpackage

/* hdl/mwg_in_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mwg_in_if
// Request channel: restart or next box.
// ----------------------------------------------------------------------------
interface mwg_in_if;
  logic valid;
  logic ready;
  logic restart;
  modport source (output valid, output restart, input ready);
  modport sink (input valid, input restart, output ready);
endinterface

/* hdl/mwg_out_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mwg_out_if
// Result channel: one box or the exhausted mark.
// ----------------------------------------------------------------------------
interface mwg_out_if;
  logic        valid;
  logic        ready;
  logic [11:0] box_x;
  logic [11:0] box_y;
  logic [11:0] box_width;
  logic [11:0] box_height;
  logic [4:0]  scale_index;
  logic        exhausted;
  modport source (output valid, output box_x, output box_y, output box_width,
                  output box_height, output scale_index, output exhausted, input ready);
  modport sink (input valid, input box_x, input box_y, input box_width,
                input box_height, input scale_index, input exhausted, output ready);
endinterface

/* hdl/mwg_cfg_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mwg_cfg_if
// Register write channel.
// ----------------------------------------------------------------------------
interface mwg_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [15:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

/* hdl/multiscale_window_generator_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multiscale_window_generator_unit
// Sliding-window box generator over a table of scales built at restart.
// ----------------------------------------------------------------------------
// Next box: accept, then load result and step; the load waits while an unread result is held.
// Scale change: each scale tried is read, put through two multiplies and checked, on one shared multiplier.
// Restart: setup, then for each scale step of the table a multiply and a bit-serial
//   divider with 44 quotient bits, one a cycle, then the scale search.
// Reset: synchronous, active low; exhausted until the first restart.
module multiscale_window_generator_unit
  import mwg_pkg::*;
#(
  parameter int MAX_SCALES      = 10,
  parameter int SCALE_FRAC_BITS = 16
) (
  input logic      clk,
  input logic      rst_n,
  mwg_in_if.sink   in_ch,
  mwg_out_if.source out_ch,
  mwg_cfg_if.sink  cfg_ch
);

  localparam int Depth  = 2 * MAX_SCALES + 1;
  localparam int IdxW   = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int SW     = IdxW + 1;
  localparam int MulW   = TableBits + FactorBits;
  localparam int DvdW   = TableBits + FactorFrac;
  localparam int SzW    = MulW + 1 - SCALE_FRAC_BITS;
  localparam int CntW   = $clog2(DvdW);
  localparam logic [TableBits-1:0] One = TableBits'(1) << SCALE_FRAC_BITS;
  localparam logic [MulW:0] Half = (MulW+1)'(1) << (SCALE_FRAC_BITS - 1);

  typedef enum logic [3:0] {
    S_IDLE, S_BINIT, S_BMUL, S_BDIV, S_SEEK, S_MULW, S_MULH, S_CHECK, S_EMIT
  } state_t;

  // configuration registers
  coord_t base_w_r, base_h_r, img_w_r, img_h_r, min_side_r;
  logic [CountBits-1:0]  scales_r;
  logic [FactorBits-1:0] factor_r;
  logic [ShiftBits-1:0]  shift_r;

  state_t state_r;
  logic   pending_r, active_r;
  logic [CountBits-1:0]  n_r, i_r;
  logic [FactorBits-1:0] f_r;
  logic [TableBits-1:0]  up_r, dn_r, tabv_r;
  logic [MulW-1:0]       mul_r;
  logic [DvdW-1:0]       dvd_r;
  logic [FactorBits:0]   rem_r;
  logic [CntW-1:0]       cnt_r;
  logic [SW-1:0]         s_r;
  logic [SzW-1:0]        w_r;
  coord_t col_r, row_r, cw_r, ch_r, cstep_r, rstep_r;
  logic [TableBits-1:0]  tab_r [Depth];

  logic out_valid_r, out_exh_r;
  coord_t ox_r, oy_r, ow_r, oh_r;
  logic [IndexBits-1:0] os_r;

  // shared multiplier
  logic [TableBits-1:0]  mul_a;
  logic [FactorBits-1:0] mul_b;
  logic [MulW-1:0]       mul_p;
  always_comb begin
    unique case (state_r)
      S_BMUL:  begin mul_a = up_r;   mul_b = f_r; end
      S_MULW:  begin mul_a = tabv_r; mul_b = FactorBits'(base_w_r); end
      default: begin mul_a = tabv_r; mul_b = FactorBits'(base_h_r); end
    endcase
    mul_p = MulW'(mul_a) * MulW'(mul_b);
  end

  // rounded scaled size and rounded up-scale entry
  logic [MulW:0]          size_sum;
  logic [SzW-1:0]         size_v;
  logic [MulW:0]          up_sum;
  logic [TableBits-1:0]   up_v;
  always_comb begin
    size_sum = {1'b0, mul_r} + Half;
    size_v   = size_sum[MulW:SCALE_FRAC_BITS];
    up_sum   = {1'b0, mul_r} + (MulW+1)'(2048);
    up_v     = (up_sum[MulW:TableBits+FactorFrac] != '0) ? '1
             : up_sum[TableBits+FactorFrac-1:FactorFrac];
  end

  // divider step
  logic [FactorBits:0] rem_t, rem_d;
  logic                qbit;
  logic [DvdW-1:0]     quo_v;
  always_comb begin
    rem_t = {rem_r[FactorBits-1:0], dvd_r[DvdW-1]};
    qbit  = (rem_t >= {1'b0, f_r});
    rem_d = qbit ? rem_t - {1'b0, f_r} : rem_t;
    quo_v = {dvd_r[DvdW-2:0], qbit};
  end

  // scale acceptance
  logic [SzW-1:0] ws, hs, ms;
  logic           scale_ok, seek_go;
  always_comb begin
    ws = w_r;
    hs = size_v;
    ms = (ws < hs) ? ws : hs;
    scale_ok = !(ms < SzW'(min_side_r)) && !(ws > SzW'(img_w_r)) && !(hs > SzW'(img_h_r))
               && (SzW'(img_w_r) - ws > SzW'(1)) && (SzW'(img_h_r) - hs > SzW'(1));
    seek_go  = (8'(s_r) <= {3'b0, n_r, 1'b0}) && (8'(s_r) < 8'(Depth));
  end

  // box stepping
  logic [CoordBits:0] nx, ny;
  logic               col_ok, row_ok;
  always_comb begin
    nx = {1'b0, col_r} + {1'b0, cstep_r};
    ny = {1'b0, row_r} + {1'b0, rstep_r};
    col_ok = (img_w_r >= cw_r) && (nx < {1'b0, img_w_r - cw_r});
    row_ok = (img_w_r >= cw_r) && (coord_t'(1) < img_w_r - cw_r)
             && (img_h_r >= ch_r) && (ny < {1'b0, img_h_r - ch_r});
  end

  // result register load
  logic emit_go;
  assign emit_go = (state_r == S_EMIT) && (!out_valid_r || out_ch.ready);

  // table write port
  logic                 tab_we;
  logic [IdxW-1:0]      tab_wa;
  logic [TableBits-1:0] tab_wd;
  always_comb begin
    tab_we = 1'b0;
    tab_wa = IdxW'({1'b0, n_r} + {1'b0, i_r});
    tab_wd = up_v;
    priority if (state_r == S_BINIT) begin
      tab_we = 1'b1;
      tab_wa = IdxW'(n_r);
      tab_wd = One;
    end else if (state_r == S_BDIV && cnt_r == '0) begin
      tab_we = 1'b1;
    end else if (state_r == S_BDIV && cnt_r == CntW'(DvdW - 1)) begin
      tab_we = 1'b1;
      tab_wa = IdxW'({1'b0, n_r} - {1'b0, i_r});
      tab_wd = quo_v[TableBits-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (tab_we) begin
      tab_r[tab_wa] <= tab_wd;
    end
  end

  // configuration registers
  assign cfg_ch.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_w_r   <= 12'd32;
      base_h_r   <= 12'd32;
      img_w_r    <= 12'd640;
      img_h_r    <= 12'd480;
      scales_r   <= 4'd10;
      factor_r   <= 16'd4915;
      min_side_r <= 12'd15;
      shift_r    <= 8'd26;
    end else if (cfg_ch.valid) begin
      unique case (cfg_reg_t'(cfg_ch.index))
        REG_BASE_W:   base_w_r   <= cfg_ch.data[CoordBits-1:0];
        REG_BASE_H:   base_h_r   <= cfg_ch.data[CoordBits-1:0];
        REG_IMAGE_W:  img_w_r    <= cfg_ch.data[CoordBits-1:0];
        REG_IMAGE_H:  img_h_r    <= cfg_ch.data[CoordBits-1:0];
        REG_SCALES:   scales_r   <= cfg_ch.data[CountBits-1:0];
        REG_FACTOR:   factor_r   <= cfg_ch.data;
        REG_MIN_SIDE: min_side_r <= cfg_ch.data[CoordBits-1:0];
        REG_SHIFT:    shift_r    <= cfg_ch.data[ShiftBits-1:0];
      endcase
    end
  end

  assign in_ch.ready = (state_r == S_IDLE);

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pending_r   <= 1'b0;
      active_r    <= 1'b0;
      out_valid_r <= 1'b0;
      s_r <= '0; col_r <= '0; row_r <= '0; cw_r <= '0; ch_r <= '0;
      cstep_r <= '0; rstep_r <= '0; n_r <= '0; i_r <= '0; cnt_r <= '0;
    end else begin
      if (out_ch.ready && !emit_go) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_ch.valid) begin
            pending_r <= 1'b1;
            state_r   <= in_ch.restart ? S_BINIT : S_EMIT;
          end
        end
        S_BINIT: begin
          n_r   <= (scales_r > CountBits'(MAX_SCALES)) ? CountBits'(MAX_SCALES) : scales_r;
          f_r   <= (factor_r < FactorBits'(4096)) ? FactorBits'(4096) : factor_r;
          up_r  <= One;
          dn_r  <= One;
          i_r   <= CountBits'(1);
          s_r   <= '0;
          // n_r is written this cycle; stay until n_r and f_r hold their new values, so the entry at n is written
          if (n_r == ((scales_r > CountBits'(MAX_SCALES)) ? CountBits'(MAX_SCALES)
                      : scales_r) && f_r == ((factor_r < FactorBits'(4096))
                      ? FactorBits'(4096) : factor_r)) begin
            state_r <= (n_r == '0) ? S_SEEK : S_BMUL;
          end else begin
            state_r <= S_BINIT;
          end
        end
        S_BMUL: begin
          mul_r   <= mul_p;
          dvd_r   <= {dn_r, FactorFrac'(0)} + DvdW'(f_r >> 1);
          rem_r   <= '0;
          cnt_r   <= '0;
          state_r <= S_BDIV;
        end
        S_BDIV: begin
          if (cnt_r == '0) begin
            up_r <= up_v;
          end
          rem_r <= rem_d;
          dvd_r <= quo_v;
          cnt_r <= cnt_r + CntW'(1);
          if (cnt_r == CntW'(DvdW - 1)) begin
            dn_r <= quo_v[TableBits-1:0];
            i_r  <= i_r + CountBits'(1);
            state_r <= (i_r == n_r) ? S_SEEK : S_BMUL;
          end
        end
        S_SEEK: begin
          if (seek_go) begin
            tabv_r  <= tab_r[s_r[IdxW-1:0]];
            state_r <= S_MULW;
          end else begin
            active_r <= 1'b0;
            state_r  <= pending_r ? S_EMIT : S_IDLE;
          end
        end
        S_MULW: begin
          mul_r   <= mul_p;
          state_r <= S_MULH;
        end
        S_MULH: begin
          w_r     <= size_v;
          mul_r   <= mul_p;
          state_r <= S_CHECK;
        end
        S_CHECK: begin
          if (scale_ok) begin
            cw_r     <= ws[CoordBits-1:0];
            ch_r     <= hs[CoordBits-1:0];
            cstep_r  <= step_for(shift_r, ws[CoordBits-1:0]);
            rstep_r  <= step_for(shift_r, hs[CoordBits-1:0]);
            col_r    <= coord_t'(1);
            row_r    <= coord_t'(1);
            active_r <= 1'b1;
            state_r  <= pending_r ? S_EMIT : S_IDLE;
          end else begin
            s_r     <= s_r + SW'(1);
            state_r <= S_SEEK;
          end
        end
        S_EMIT: begin
          if (emit_go) begin
            out_valid_r <= 1'b1;
            out_exh_r   <= !active_r;
            ox_r <= active_r ? col_r : '0;
            oy_r <= active_r ? row_r : '0;
            ow_r <= active_r ? cw_r : '0;
            oh_r <= active_r ? ch_r : '0;
            os_r <= active_r ? IndexBits'(s_r) : '0;
            pending_r <= 1'b0;
            state_r   <= (active_r && !col_ok && !row_ok) ? S_SEEK : S_IDLE;
            if (active_r) begin
              priority if (col_ok) begin
                col_r <= nx[CoordBits-1:0];
              end else if (row_ok) begin
                col_r <= coord_t'(1);
                row_r <= ny[CoordBits-1:0];
              end else begin
                s_r <= s_r + SW'(1);
              end
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.box_x       = ox_r;
  assign out_ch.box_y       = oy_r;
  assign out_ch.box_width   = ow_r;
  assign out_ch.box_height  = oh_r;
  assign out_ch.scale_index = os_r;
  assign out_ch.exhausted   = out_exh_r;

  // checks
  a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("request taken while idle left block ready");
  a_exh_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.exhausted) |-> (out_ch.box_width == '0 && out_ch.box_x == '0))
    else $error("exhausted result carries a box");
  a_div_len: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_BDIV) |-> (cnt_r <= CntW'(DvdW - 1)))
    else $error("divider ran past its length");

endmodule
